/* rtl/sat_pkg.sv */
`default_nettype none
package sat_pkg;

	localparam int NUM_WAYS    = 16;
	localparam int NUM_ENTRIES = 256;
	localparam int PID_WIDTH   = 8;

	localparam int SETS  = (NUM_ENTRIES / NUM_WAYS) > 0 ? (NUM_ENTRIES / NUM_WAYS) : 1;
	localparam int SET_W = SETS > 1 ? $clog2(SETS) : 1;
	localparam int WAY_W = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;

	localparam int PAGE_W  = 20;
	localparam int FRAME_W = 20;

	typedef enum logic [1:0] {
		KIND_XLATE = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [PAGE_W-1:0]    page;
		logic                 glob;
		logic [PID_WIDTH-1:0] pid;
		logic [FRAME_W-1:0]   frame;
		logic                 cache;
		logic                 rd;
		logic                 wr;
		logic                 ex;
	} entry_t;

	typedef struct packed {
		logic   hit;
		entry_t entry;
	} match_t;

endpackage
`default_nettype wire

/* rtl/sat_store.sv */
`default_nettype none
module sat_store import sat_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic             wr_en,
	input  wire logic [SET_W-1:0] set_idx,
	input  wire logic [WAY_W-1:0] way_idx,
	input  wire entry_t           wdata,
	output entry_t                row [NUM_WAYS]
);

	// one row per set, one entry per way; ways written individually
	entry_t mem_q [SETS][NUM_WAYS];
	logic [NUM_WAYS-1:0] valid_q [SETS];

	entry_t row_s1 [NUM_WAYS];
	logic [NUM_WAYS-1:0] vrow_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[set_idx][way_idx] <= wdata;
		end
		if (rd_en) begin
			row_s1 <= mem_q[set_idx];
		end
	end

	// entries never written read as zero, as after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
			vrow_s1 <= '0;
		end else begin
			if (wr_en) begin
				valid_q[set_idx][way_idx] <= 1'b1;
			end
			if (rd_en) begin
				vrow_s1 <= valid_q[set_idx];
			end
		end
	end

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			row[w] = vrow_s1[w] ? row_s1[w] : '0;
		end
	end

endmodule
`default_nettype wire

/* rtl/sat_match.sv */
`default_nettype none
module sat_match import sat_pkg::*; (
	input  wire entry_t               row [NUM_WAYS],
	input  wire logic [PAGE_W-1:0]    page,
	input  wire logic [PID_WIDTH-1:0] pid,
	output match_t                    res
);

	logic [NUM_WAYS-1:0] match;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w] = (row[w].page == page) && (row[w].glob || (row[w].pid == pid));
		end
	end

	// lowest matching way wins: scan downwards so it is taken last
	always_comb begin
		res = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				res.hit   = 1'b1;
				res.entry = row[w];
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/set_assoc_tlb_lookup_and_update.sv */
// Set-associative TLB with process-id tags.
// Input channel (in_valid / in_stall) carries one item: translate, write entry
// or read entry. Output channel (out_valid / out_stall) returns one result per
// item, in order; a write returns an all-zero result.
// A transfer at the input reads the selected set from the entry memory into the
// row register (a write updates its way at the same edge); all ways are then
// compared and the result is registered in the output register, from which it
// leaves once the receiver does not stall.
// Throughput is one item per cycle while the receiver does not stall: the row
// read and the output register form a two-deep pipeline with no bubble.
// When the receiver stalls, the output holds; the stage behind it still takes
// one more item, then in_stall rises until the output is taken.
// Reset clears the per-entry valid bits at once, so every entry reads as zero
// (page 0, process 0, no permissions) until written; no clearing pass is needed
// and items are taken as soon as reset is released.
`default_nettype none
module set_assoc_tlb_lookup_and_update import sat_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           kind,
	input  wire logic [19:0]          page_number,
	input  wire logic [7:0]           proc_id,
	input  wire logic [3:0]           way_sel,
	input  wire logic                 global_in,
	input  wire logic [19:0]          frame_in,
	input  wire logic                 cache_in,
	input  wire logic                 read_in,
	input  wire logic                 write_in,
	input  wire logic                 exec_in,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic [19:0]               frame_out,
	output logic                      cache_out,
	output logic                      read_ok,
	output logic                      write_ok,
	output logic                      exec_ok,
	output logic [19:0]               entry_page,
	output logic [7:0]                entry_pid,
	output logic                      entry_global
);

	logic advance;
	logic accept;
	logic way_ok;
	logic wr_en;
	entry_t wdata;
	entry_t row [NUM_WAYS];
	match_t mres;

	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic [PAGE_W-1:0]    page_s1;
	logic [PID_WIDTH-1:0] pid_s1;
	logic [WAY_W-1:0]     way_s1;
	logic                 way_ok_s1;

	entry_t rd_entry;
	logic   res_hit;
	entry_t res_entry;
	logic   res_tag;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign way_ok = {1'b0, way_sel} < 5'(NUM_WAYS);
	assign wr_en  = accept && (kind == KIND_WRITE) && way_ok;

	always_comb begin
		wdata       = '0;
		wdata.page  = page_number;
		wdata.glob  = global_in;
		wdata.pid   = proc_id[PID_WIDTH-1:0];
		wdata.frame = frame_in;
		wdata.cache = cache_in;
		wdata.rd    = read_in;
		wdata.wr    = write_in;
		wdata.ex    = exec_in;
	end

	sat_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.wr_en   (wr_en),
		.set_idx (page_number[SET_W-1:0]),
		.way_idx (way_sel[WAY_W-1:0]),
		.wdata   (wdata),
		.row     (row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			page_s1   <= page_number;
			pid_s1    <= proc_id[PID_WIDTH-1:0];
			way_s1    <= way_sel[WAY_W-1:0];
			way_ok_s1 <= way_ok;
		end
	end

	sat_match u_match (
		.row  (row),
		.page (page_s1),
		.pid  (pid_s1),
		.res  (mres)
	);

	always_comb begin
		rd_entry  = row[way_s1];
		res_hit   = 1'b0;
		res_entry = '0;
		res_tag   = 1'b0;
		case (kind_s1)
			KIND_XLATE: begin
				res_hit   = mres.hit;
				res_entry = mres.entry;
			end
			KIND_READ: begin
				if (way_ok_s1) begin
					res_entry = rd_entry;
					res_tag   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			hit          <= res_hit;
			frame_out    <= res_entry.frame;
			cache_out    <= res_entry.cache;
			read_ok      <= res_entry.rd;
			write_ok     <= res_entry.wr;
			exec_ok      <= res_entry.ex;
			entry_page   <= res_tag ? res_entry.page : '0;
			entry_pid    <= res_tag ? 8'(res_entry.pid) : '0;
			entry_global <= res_tag ? res_entry.glob : 1'b0;
		end
	end

	// a hit result never carries read-back tag fields
	a_hit_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> entry_page == '0 && entry_pid == '0 && !entry_global)
		else $error("hit result carries tag fields");

	// the input only stalls with both stages full and the output blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with free pipeline stage");

	// a result waiting in the first stage moves out once the output is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid |=> out_valid)
		else $error("result lost between stages");

endmodule
`default_nettype wire
